/* rtl/w512_pkg.sv */
// Shared types and constants for the WELL512 bounded random generator.
// No dependencies; imported by every module of the block.
package w512_pkg;

    localparam int WORD_W      = 32;
    localparam int SEED_W      = 64;
    localparam int NUM_WORDS   = 16;
    localparam int DIV_CNT_W   = $clog2(WORD_W);
    localparam int WARMUP_STEPS_DEF = 128;

    localparam logic [SEED_W-1:0] SEED_MASK   = 64'h0102030405060708;
    localparam logic [WORD_W-1:0] TEMPER_MASK = 32'hDA442D24;
    localparam logic [WORD_W-1:0] FULL_WORD   = 32'hFFFFFFFF;

    // generator control
    typedef struct packed {
        logic load;
        logic step;
    } gen_ctl_t;

    // divider control; clear aborts a division in flight
    typedef struct packed {
        logic start;
        logic clear;
    } div_ctl_t;

endpackage

/* rtl/w512_gen.sv */
// WELL512 state held as a rotating line of 16 words, one generator step per cycle while step is set.
// Depends on w512_pkg.
module w512_gen (
    input  logic                       clk,
    input  w512_pkg::gen_ctl_t         ctl,
    input  logic [w512_pkg::SEED_W-1:0] seed,
    output logic [w512_pkg::WORD_W-1:0] word
);
    import w512_pkg::*;

    // words_reg[k] holds generator word (ring position + k) mod 16
    logic [WORD_W-1:0] words_reg [NUM_WORDS];
    logic [WORD_W-1:0] words_next [NUM_WORDS];
    logic [SEED_W-1:0] mixed;
    logic [WORD_W-1:0] x, y, z0, z, t, nw, tw, w;

    assign mixed = seed ^ SEED_MASK;

    always_comb begin
        x  = words_reg[0];
        y  = words_reg[13];
        z0 = words_reg[9];
        w  = words_reg[15];
        t  = x ^ y ^ (x << 16) ^ (y << 15);
        z  = z0 ^ (z0 >> 11);
        nw = t ^ z;
        tw = nw ^ ((nw << 5) & TEMPER_MASK);
        word = w ^ t ^ tw ^ (w << 2) ^ (t << 18) ^ (z << 28);
    end

    // on a step, ring position moves back by one: line rotates by one place
    always_comb begin
        for (int k = 0; k < NUM_WORDS; k++) begin
            if (ctl.load) begin
                words_next[k] = (k % 2 == 0) ? mixed[WORD_W-1:0] : mixed[SEED_W-1:WORD_W];
            end else if (ctl.step) begin
                if (k == 0) begin
                    words_next[k] = word;
                end else if (k == 1) begin
                    words_next[k] = nw;
                end else begin
                    words_next[k] = words_reg[k-1];
                end
            end else begin
                words_next[k] = words_reg[k];
            end
        end
    end

    always_ff @(posedge clk) begin
        for (int k = 0; k < NUM_WORDS; k++) begin
            words_reg[k] <= words_next[k];
        end
    end

endmodule

/* rtl/w512_div.sv */
// Radix-2 restoring divider giving the remainder, one quotient bit per cycle.
// Depends on w512_pkg.
module w512_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  w512_pkg::div_ctl_t          ctl,
    input  logic [w512_pkg::WORD_W-1:0] dividend,
    input  logic [w512_pkg::WORD_W-1:0] divisor,
    output logic                        done,
    output logic [w512_pkg::WORD_W-1:0] rem
);
    import w512_pkg::*;

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [WORD_W-1:0]    rem_reg;
    logic [WORD_W-1:0]    rem_next;
    logic [WORD_W-1:0]    dvd_reg;
    logic [WORD_W-1:0]    dsr_reg;
    logic [WORD_W:0]      trial;
    logic [WORD_W:0]      diff;

    always_comb begin
        trial    = {rem_reg, dvd_reg[WORD_W-1]};
        diff     = trial - {1'b0, dsr_reg};
        rem_next = (trial >= {1'b0, dsr_reg}) ? diff[WORD_W-1:0] : trial[WORD_W-1:0];
    end

    always_ff @(posedge clk) begin
        if (!rst_n || ctl.clear) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (ctl.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + DIV_CNT_W'(1);
                if (cnt_reg == DIV_CNT_W'(WORD_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk) begin
        if (ctl.start) begin
            rem_reg <= '0;
            dvd_reg <= dividend;
            dsr_reg <= divisor;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            dvd_reg <= {dvd_reg[WORD_W-2:0], 1'b0};
        end
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule

/* rtl/well512_bounded_random_top.sv */
// Flow to m_valid: a raw word takes one generator draw, bound zero returns the fallback, and a
// bounded draw runs two remainder passes in the shared divider, with a redraw per rejected word.
// Throughput: one item at a time, s_ready only while idle.
// Reset and each seed write load the state, then run WARMUP_STEPS generator steps
// (one per cycle) before s_ready rises. Reset acts as a write of seed zero.
// Depends on w512_pkg, w512_gen, w512_div.
module well512_bounded_random_top #(
    parameter int WARMUP_STEPS = w512_pkg::WARMUP_STEPS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        seed_wr_en,
    input  logic [w512_pkg::SEED_W-1:0] seed_wr_data,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic                        s_req_type,
    input  logic [w512_pkg::WORD_W-1:0] s_bound,
    input  logic [w512_pkg::WORD_W-1:0] s_fallback,
    input  logic [w512_pkg::WORD_W-1:0] s_base,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [w512_pkg::WORD_W-1:0] m_value
);
    import w512_pkg::*;

    localparam int WarmCntW = (WARMUP_STEPS > 1) ? $clog2(WARMUP_STEPS) : 1;
    localparam int WarmLast = (WARMUP_STEPS > 0) ? WARMUP_STEPS - 1 : 0;

    typedef enum logic [6:0] {
        ST_LOAD = 7'b0000001,
        ST_WARM = 7'b0000010,
        ST_IDLE = 7'b0000100,
        ST_DIV1 = 7'b0001000,
        ST_DRAW = 7'b0010000,
        ST_DIV2 = 7'b0100000,
        ST_FIN  = 7'b1000000
    } state_t;

    state_t              state_reg, state_next;
    logic [WarmCntW-1:0] warm_cnt_reg, warm_cnt_next;
    logic [SEED_W-1:0]   seed_reg;
    logic                raw_reg;
    logic [WORD_W-1:0]   bound_reg;
    logic [WORD_W-1:0]   base_reg;
    logic [WORD_W-1:0]   limit_reg;
    logic [WORD_W-1:0]   result_reg;
    logic                m_valid_reg;
    logic [WORD_W-1:0]   m_value_reg;

    gen_ctl_t            gen_ctl;
    div_ctl_t            div_ctl;
    logic [WORD_W-1:0]   gen_word;
    logic [WORD_W-1:0]   div_dividend, div_divisor, div_rem;
    logic                div_done;
    logic                accept, out_free, word_ok;

    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign word_ok  = gen_word <= limit_reg;

    always_comb begin
        state_next    = state_reg;
        warm_cnt_next = warm_cnt_reg;
        gen_ctl       = '0;
        div_ctl       = '0;
        div_dividend  = gen_word;
        div_divisor   = bound_reg;
        s_ready       = 1'b0;
        unique case (state_reg)
            ST_LOAD: begin
                gen_ctl.load  = 1'b1;
                warm_cnt_next = '0;
                state_next    = (WARMUP_STEPS == 0) ? ST_IDLE : ST_WARM;
            end
            ST_WARM: begin
                gen_ctl.step  = 1'b1;
                warm_cnt_next = warm_cnt_reg + WarmCntW'(1);
                if (warm_cnt_reg == WarmCntW'(WarmLast)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_ready      = 1'b1;
                div_dividend = FULL_WORD;
                div_divisor  = s_bound;
                if (accept) begin
                    if (!s_req_type) begin
                        state_next = ST_DRAW;
                    end else if (s_bound == '0) begin
                        state_next = ST_FIN;
                    end else begin
                        div_ctl.start = 1'b1;
                        state_next    = ST_DIV1;
                    end
                end
            end
            ST_DIV1: begin
                if (div_done) begin
                    state_next = ST_DRAW;
                end
            end
            ST_DRAW: begin
                gen_ctl.step = 1'b1;
                if (raw_reg) begin
                    state_next = ST_FIN;
                end else if (word_ok) begin
                    div_ctl.start = 1'b1;
                    state_next    = ST_DIV2;
                end
            end
            ST_DIV2: begin
                if (div_done) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
        if (seed_wr_en) begin
            state_next = ST_LOAD;
        end
        div_ctl.clear = seed_wr_en || (state_reg == ST_LOAD);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_LOAD;
            warm_cnt_reg <= '0;
            seed_reg     <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            warm_cnt_reg <= warm_cnt_next;
            if (seed_wr_en) begin
                seed_reg <= seed_wr_data;
            end
            if (state_reg == ST_FIN && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            raw_reg    <= !s_req_type;
            bound_reg  <= s_bound;
            base_reg   <= s_base;
            result_reg <= s_fallback;
        end
        // limit = bound * floor(0xFFFFFFFF / bound) = 0xFFFFFFFF - remainder
        if (state_reg == ST_DIV1 && div_done) begin
            limit_reg <= ~div_rem;
        end
        if (state_reg == ST_DRAW && raw_reg) begin
            result_reg <= gen_word;
        end
        if (state_reg == ST_DIV2 && div_done) begin
            result_reg <= base_reg + div_rem;
        end
        if (state_reg == ST_FIN && out_free) begin
            m_value_reg <= result_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_value = m_value_reg;

    w512_gen u_gen (
        .clk  (aclk),
        .ctl  (gen_ctl),
        .seed (seed_reg),
        .word (gen_word)
    );

    w512_div u_div (
        .clk      (aclk),
        .rst_n    (aresetn),
        .ctl      (div_ctl),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .rem      (div_rem)
    );

`ifndef SYNTH
    // divider completes only while the sequencer waits on it
    a_div_done_state: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == ST_DIV1 || state_reg == ST_DIV2))
        else $error("divider done outside a divide state");

    // one item at a time: no second transfer right after a transfer
    a_single_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input ready right after a transfer");

    // finished result waits while the output register is occupied
    a_fin_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FIN && m_valid_reg && !m_ready && !seed_wr_en)
        |=> state_reg == ST_FIN)
        else $error("result left the finish state while output was blocked");
`endif

endmodule
